// ----- src/ams_pkg.sv -----
// ams_pkg: types, constants and helper functions of the arc subdivider
// depends on nothing; used by arc_monotonic_subdivider_unit
package ams_pkg;

    localparam int MAX_SUBARCS_DEF = 24;
    localparam int CNT_W   = 5;
    localparam int MAG_W   = 21;
    localparam int ACC_W   = 26;
    localparam int Z_W     = 29;
    localparam int XY_W    = 33;
    localparam int PROD_W  = 55;
    localparam int CORDIC_STEPS = 24;

    localparam logic [MAG_W-1:0] QPI4 = 21'd51472;
    localparam logic signed [Z_W-1:0] PI24   = 29'sd52707179;
    localparam logic signed [Z_W-1:0] TWOPI24 = 29'sd105414358;
    localparam logic signed [Z_W-1:0] HPI24  = 29'sd26353589;
    localparam logic signed [XY_W-1:0] KINIT = 33'sd652032874;

    typedef struct packed {
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] finish_x;
        logic signed [23:0] finish_y;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic        [22:0] arc_radius;
        logic signed [19:0] angle_from;
        logic signed [19:0] angle_to;
    } t_arc_in;

    typedef struct packed {
        logic signed [23:0] seg_start_x;
        logic signed [23:0] seg_start_y;
        logic signed [23:0] seg_end_x;
        logic signed [23:0] seg_end_y;
        logic signed [19:0] seg_angle_from;
        logic signed [19:0] seg_angle_to;
        logic               tangent_prev;
        logic               last_of_arc;
    } t_seg_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_PINIT, ST_COUNT, ST_KSTEP, ST_DIV, ST_ANGLE,
        ST_REDUCE, ST_ROTATE, ST_MULX, ST_ADDX, ST_MULY, ST_ADDY, ST_EMIT
    } t_state;

    typedef struct packed {
        logic                  neg;
        logic signed [Z_W-1:0] z;
    } t_red;

    function automatic logic signed [19:0] split_angle(input logic [2:0] kk);
        case (kk)
            3'd0:    split_angle = -20'sd102944;
            3'd1:    split_angle = 20'sd0;
            3'd2:    split_angle = 20'sd102944;
            3'd3:    split_angle = 20'sd205887;
            3'd4:    split_angle = 20'sd308831;
            3'd5:    split_angle = 20'sd411775;
            default: split_angle = 20'sd514719;
        endcase
    endfunction

    function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] j);
        case (j)
            5'd0:    atan_step = 29'sd13176795;
            5'd1:    atan_step = 29'sd7778716;
            5'd2:    atan_step = 29'sd4110060;
            5'd3:    atan_step = 29'sd2086331;
            5'd4:    atan_step = 29'sd1047214;
            5'd5:    atan_step = 29'sd524117;
            5'd6:    atan_step = 29'sd262122;
            5'd7:    atan_step = 29'sd131069;
            default: atan_step = 29'sd1 <<< (5'd24 - j);
        endcase
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607) begin
            sat24 = 24'sh7fffff;
        end else if (v < -27'sd8388608) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = v[23:0];
        end
    endfunction

    function automatic t_red reduce_angle(input logic signed [19:0] a);
        logic signed [Z_W-1:0] z;
        t_red r;
        z = {{(Z_W-28){a[19]}}, a, 8'd0};
        // a 20 bit angle lands in [-pi, pi] after one 2pi step
        if (z > PI24) begin
            z = z - TWOPI24;
        end else if (z < -PI24) begin
            z = z + TWOPI24;
        end
        r.neg = 1'b0;
        if (z > HPI24) begin
            z = z - PI24;
            r.neg = 1'b1;
        end else if (z < -HPI24) begin
            z = z + PI24;
            r.neg = 1'b1;
        end
        r.z = z;
        return r;
    endfunction

endpackage

// ----- src/arc_monotonic_subdivider_unit.sv -----
// arc_monotonic_subdivider_unit: splits one circular arc into monotonic sub-arcs
// depends on ams_pkg (types, split angles, cordic table, saturation)
//
// usage
//   input channel: i_in_valid / o_in_ready, one arc per beat in i_in_beat
//   output channel: o_out_valid / i_out_ready, one sub-arc per beat in o_out_beat,
//   last_of_arc marks the final beat of an arc (at most MAX_SUBARCS beats)
//   o_in_ready is high only while the sequencer is idle; an arc is worked
//   on alone from acceptance to its last beat
//   per arc: a quarter-turn scan plus sub-arc counting per piece; per
//   interior sub-arc a restoring divider, 24 cordic rotations on one shared
//   add/shift unit and two passes through one 23x32 multiplier; a
//   piece-ending sub-arc goes straight to the emit state
//   results leave through one output register: the sequencer waits in its
//   emit state while the receiver stalls and a full register is not taken
//   reset (synchronous, active low) returns to idle and drops any beat
//   still held in the output register
module arc_monotonic_subdivider_unit #(
    parameter int MAX_SUBARCS = ams_pkg::MAX_SUBARCS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ams_pkg::t_arc_in  i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ams_pkg::t_seg_out o_out_beat
);

    localparam int NW = $clog2(MAX_SUBARCS + 1);

    ams_pkg::t_state r_state, n_state;
    ams_pkg::t_arc_in r_in, n_in;
    logic r_up, n_up;
    logic [2:0] r_i, n_i;
    logic r_final, n_final;
    logic signed [19:0] r_pa, n_pa, r_a1, n_a1, r_th0, n_th0, r_th1, n_th1;
    logic signed [23:0] r_px, n_px, r_py, n_py, r_ex, n_ex, r_ey, n_ey;
    logic signed [23:0] r_nx, n_nx, r_ny, n_ny;
    logic [ams_pkg::MAG_W-1:0] r_mag, n_mag, r_remc, n_remc;
    logic r_swneg, n_swneg;
    logic [ams_pkg::CNT_W-1:0] r_cnt, n_cnt, r_k, n_k;
    logic [ams_pkg::ACC_W-1:0] r_acc, n_acc, r_dvd, n_dvd, r_quo, n_quo;
    logic [ams_pkg::CNT_W-1:0] r_drem, n_drem;
    logic [4:0] r_dc, n_dc, r_j, n_j;
    logic signed [ams_pkg::Z_W-1:0] r_z, n_z;
    logic signed [ams_pkg::XY_W-1:0] r_x, n_x, r_y, n_y;
    logic r_fneg, n_fneg;
    logic [ams_pkg::PROD_W-1:0] r_prod, n_prod;
    logic r_psgn, n_psgn;
    logic [NW-1:0] r_n, n_n;
    logic r_ov, n_ov;
    ams_pkg::t_seg_out r_ob, n_ob;

    logic [2:0] kk;
    logic signed [19:0] ca;
    logic is_split;
    logic signed [24:0] sp_x, sp_y;
    logic signed [20:0] sweep;
    logic [ams_pkg::CNT_W:0] rem_sh;
    logic signed [21:0] th_sum;
    logic signed [21:0] q_signed;
    ams_pkg::t_red red;
    logic signed [ams_pkg::XY_W-1:0] sh_x, sh_y, t_val;
    logic [31:0] t_mag;
    logic [ams_pkg::PROD_W:0] p_round;
    logic signed [26:0] p_ext, base_ext;
    logic is_last, out_free, emit_go;

    assign o_in_ready  = (r_state == ams_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_beat  = r_ob;

    assign out_free = !r_ov || i_out_ready;
    assign is_last  = (r_n == NW'(MAX_SUBARCS - 1)) ||
                      (r_final && ((r_k + 1'b1) == r_cnt));
    assign emit_go  = (r_state == ams_pkg::ST_EMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ams_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_in <= n_in; r_up <= n_up; r_i <= n_i; r_final <= n_final;
        r_pa <= n_pa; r_a1 <= n_a1; r_th0 <= n_th0; r_th1 <= n_th1;
        r_px <= n_px; r_py <= n_py; r_ex <= n_ex; r_ey <= n_ey;
        r_nx <= n_nx; r_ny <= n_ny; r_mag <= n_mag; r_remc <= n_remc;
        r_swneg <= n_swneg; r_cnt <= n_cnt; r_k <= n_k; r_acc <= n_acc;
        r_dvd <= n_dvd; r_quo <= n_quo; r_drem <= n_drem; r_dc <= n_dc;
        r_j <= n_j; r_z <= n_z; r_x <= n_x; r_y <= n_y; r_fneg <= n_fneg;
        r_prod <= n_prod; r_psgn <= n_psgn; r_n <= n_n; r_ob <= n_ob;
    end

    always_comb begin
        n_state = r_state;
        n_in = r_in; n_up = r_up; n_i = r_i; n_final = r_final;
        n_pa = r_pa; n_a1 = r_a1; n_th0 = r_th0; n_th1 = r_th1;
        n_px = r_px; n_py = r_py; n_ex = r_ex; n_ey = r_ey;
        n_nx = r_nx; n_ny = r_ny; n_mag = r_mag; n_remc = r_remc;
        n_swneg = r_swneg; n_cnt = r_cnt; n_k = r_k; n_acc = r_acc;
        n_dvd = r_dvd; n_quo = r_quo; n_drem = r_drem; n_dc = r_dc;
        n_j = r_j; n_z = r_z; n_x = r_x; n_y = r_y; n_fneg = r_fneg;
        n_prod = r_prod; n_psgn = r_psgn; n_n = r_n; n_ob = r_ob;
        n_ov = r_ov && !i_out_ready;

        kk = r_up ? r_i : (3'd6 - r_i);
        ca = ams_pkg::split_angle(kk);
        is_split = r_up ? (r_in.angle_from < ca && ca < r_in.angle_to)
                        : (r_in.angle_to < ca && ca < r_in.angle_from);
        sp_x = {r_in.center_x[23], r_in.center_x};
        sp_y = {r_in.center_y[23], r_in.center_y};
        if (kk[0]) begin
            if (kk == 3'd3) begin
                sp_x = sp_x - $signed({2'b00, r_in.arc_radius});
            end else begin
                sp_x = sp_x + $signed({2'b00, r_in.arc_radius});
            end
        end else begin
            if (kk == 3'd0 || kk == 3'd4) begin
                sp_y = sp_y - $signed({2'b00, r_in.arc_radius});
            end else begin
                sp_y = sp_y + $signed({2'b00, r_in.arc_radius});
            end
        end
        sweep  = {r_a1[19], r_a1} - {r_pa[19], r_pa};
        rem_sh = {r_drem, r_dvd[ams_pkg::ACC_W-1]};
        q_signed = $signed({1'b0, r_quo[20:0]});
        th_sum = {{2{r_pa[19]}}, r_pa} + (r_swneg ? -q_signed : q_signed);
        red = ams_pkg::reduce_angle(r_th1);
        sh_x = r_x >>> r_j;
        sh_y = r_y >>> r_j;
        t_val = (r_state == ams_pkg::ST_MULX) ? r_x : r_y;
        if (r_fneg) begin
            t_val = -t_val;
        end
        t_mag = t_val[ams_pkg::XY_W-1] ? 32'(-t_val) : 32'(t_val);
        p_round = {1'b0, r_prod} + (ams_pkg::PROD_W+1)'(64'd1 << 29);
        p_ext = $signed({1'b0, p_round[55:30]});
        base_ext = (r_state == ams_pkg::ST_ADDX) ? 27'(r_in.center_x)
                                                : 27'(r_in.center_y);

        case (r_state)
            ams_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_in  = i_in_beat;
                    n_up  = i_in_beat.angle_from < i_in_beat.angle_to;
                    n_i   = 3'd0;
                    n_pa  = i_in_beat.angle_from;
                    n_px  = i_in_beat.start_x;
                    n_py  = i_in_beat.start_y;
                    n_n   = '0;
                    n_state = ams_pkg::ST_SCAN;
                end
            end
            ams_pkg::ST_SCAN: begin
                if (r_i == 3'd7) begin
                    n_a1 = r_in.angle_to;
                    n_ex = r_in.finish_x;
                    n_ey = r_in.finish_y;
                    n_final = 1'b1;
                    n_state = ams_pkg::ST_PINIT;
                end else begin
                    n_i = r_i + 3'd1;
                    if (is_split) begin
                        n_a1 = ca;
                        n_ex = ams_pkg::sat24(27'(sp_x));
                        n_ey = ams_pkg::sat24(27'(sp_y));
                        n_final = 1'b0;
                        n_state = ams_pkg::ST_PINIT;
                    end
                end
            end
            ams_pkg::ST_PINIT: begin
                n_swneg = sweep[20];
                n_mag   = sweep[20] ? ams_pkg::MAG_W'(-sweep) : ams_pkg::MAG_W'(sweep);
                n_remc  = n_mag;
                n_acc   = ams_pkg::ACC_W'(n_mag);
                n_cnt   = ams_pkg::CNT_W'(1);
                n_k     = '0;
                n_th0   = r_pa;
                n_state = ams_pkg::ST_COUNT;
            end
            ams_pkg::ST_COUNT: begin
                if (r_remc >= ams_pkg::QPI4) begin
                    n_remc = r_remc - ams_pkg::QPI4;
                    n_cnt  = r_cnt + 1'b1;
                end else begin
                    n_state = ams_pkg::ST_KSTEP;
                end
            end
            ams_pkg::ST_KSTEP: begin
                if ((r_k + 1'b1) == r_cnt) begin
                    n_th1 = r_a1;
                    n_nx  = r_ex;
                    n_ny  = r_ey;
                    n_state = ams_pkg::ST_EMIT;
                end else begin
                    n_dvd  = r_acc + ams_pkg::ACC_W'(r_cnt >> 1);
                    n_drem = '0;
                    n_quo  = '0;
                    n_dc   = '0;
                    n_state = ams_pkg::ST_DIV;
                end
            end
            ams_pkg::ST_DIV: begin
                n_dvd = r_dvd << 1;
                if (rem_sh >= {1'b0, r_cnt}) begin
                    n_drem = ams_pkg::CNT_W'(rem_sh - {1'b0, r_cnt});
                    n_quo  = {r_quo[ams_pkg::ACC_W-2:0], 1'b1};
                end else begin
                    n_drem = rem_sh[ams_pkg::CNT_W-1:0];
                    n_quo  = {r_quo[ams_pkg::ACC_W-2:0], 1'b0};
                end
                n_dc = r_dc + 5'd1;
                if (r_dc == 5'(ams_pkg::ACC_W - 1)) begin
                    n_state = ams_pkg::ST_ANGLE;
                end
            end
            ams_pkg::ST_ANGLE: begin
                n_th1 = th_sum[19:0];
                n_state = ams_pkg::ST_REDUCE;
            end
            ams_pkg::ST_REDUCE: begin
                n_z    = red.z;
                n_fneg = red.neg;
                n_x    = ams_pkg::KINIT;
                n_y    = '0;
                n_j    = '0;
                n_state = ams_pkg::ST_ROTATE;
            end
            ams_pkg::ST_ROTATE: begin
                if (r_z >= 0) begin
                    n_x = r_x - sh_y;
                    n_y = r_y + sh_x;
                    n_z = r_z - ams_pkg::atan_step(r_j);
                end else begin
                    n_x = r_x + sh_y;
                    n_y = r_y - sh_x;
                    n_z = r_z + ams_pkg::atan_step(r_j);
                end
                n_j = r_j + 5'd1;
                if (r_j == 5'(ams_pkg::CORDIC_STEPS - 1)) begin
                    n_state = ams_pkg::ST_MULX;
                end
            end
            ams_pkg::ST_MULX, ams_pkg::ST_MULY: begin
                n_prod  = ams_pkg::PROD_W'(r_in.arc_radius * t_mag);
                n_psgn  = t_val[ams_pkg::XY_W-1];
                n_state = (r_state == ams_pkg::ST_MULX) ? ams_pkg::ST_ADDX
                                                        : ams_pkg::ST_ADDY;
            end
            ams_pkg::ST_ADDX: begin
                n_nx = ams_pkg::sat24(r_psgn ? base_ext - p_ext : base_ext + p_ext);
                n_state = ams_pkg::ST_MULY;
            end
            ams_pkg::ST_ADDY: begin
                n_ny = ams_pkg::sat24(r_psgn ? base_ext - p_ext : base_ext + p_ext);
                n_state = ams_pkg::ST_EMIT;
            end
            ams_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ob.seg_start_x    = r_px;
                    n_ob.seg_start_y    = r_py;
                    n_ob.seg_end_x      = r_nx;
                    n_ob.seg_end_y      = r_ny;
                    n_ob.seg_angle_from = r_th0;
                    n_ob.seg_angle_to   = r_th1;
                    n_ob.tangent_prev   = (r_k != '0);
                    n_ob.last_of_arc    = is_last;
                    n_n   = r_n + 1'b1;
                    n_px  = r_nx;
                    n_py  = r_ny;
                    n_th0 = r_th1;
                    n_k   = r_k + 1'b1;
                    n_acc = r_acc + ams_pkg::ACC_W'(r_mag);
                    if (is_last) begin
                        n_state = ams_pkg::ST_IDLE;
                    end else if ((r_k + 1'b1) == r_cnt) begin
                        n_pa = r_th1;
                        n_state = ams_pkg::ST_SCAN;
                    end else begin
                        n_state = ams_pkg::ST_KSTEP;
                    end
                end
            end
            default: begin
                n_state = ams_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_SUBARCS))
        else $error("sub-arc count beyond limit");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ams_pkg::ST_KSTEP |-> (r_cnt >= 5'd1 && r_cnt <= 5'd21 && r_k < r_cnt))
        else $error("sub-arc index out of range");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go && is_last |=> r_state == ams_pkg::ST_IDLE)
        else $error("sequencer busy after last beat");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == ams_pkg::ST_SCAN && r_n == '0)
        else $error("arc not started after acceptance");
`endif

endmodule
